// ===== hdl/iert_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iert_pkg
// Shared types and constants for the idle eviction residency table.
// ----------------------------------------------------------------------------
package iert_pkg;

  localparam int unsigned Entries  = 64;
  localparam int unsigned SlotBits = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntBits  = $clog2(Entries + 1);

  typedef enum logic [2:0] {
    OP_REGISTER  = 3'd0,
    OP_MARK_USED = 3'd1,
    OP_SUGGEST   = 3'd2,
    OP_EVICT     = 3'd3,
    OP_PIN       = 3'd4,
    OP_UNPIN     = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_ZERO      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_EMIT,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] key_tag;
    logic [31:0] allocation_handle;
    logic [31:0] provider_handle;
    logic [39:0] buf_size;
    logic [31:0] iteration;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        suggestion_valid;
    logic [31:0] suggested_key;
    logic [31:0] suggested_allocation;
    logic [31:0] suggested_provider;
    logic [39:0] suggested_size;
    logic [45:0] total_bytes;
    logic        last_result;
  } out_t;

  typedef struct packed {
    logic         valid;
    logic [31:0]  key;
    logic [31:0]  alloc;
    logic [31:0]  prov;
    logic [39:0]  size;
    logic [31:0]  last_used;
    logic         pinned;
  } slot_t;

endpackage

// ===== hdl/iert_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iert_in_if / iert_out_if
// Valid/ready channels for operations and results.
// ----------------------------------------------------------------------------
interface iert_in_if;
  logic             valid;
  logic             ready;
  iert_pkg::in_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface iert_out_if;
  logic             valid;
  logic             ready;
  iert_pkg::out_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/idle_eviction_residency_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_eviction_residency_table_top
// Resident buffer table with pinning and idle-age eviction suggestions.
// ----------------------------------------------------------------------------
// Operations arrive on the in channel; results leave on the out channel, one
// transaction per result. The idle threshold is written through cfg_we and
// cfg_wdata, by the user only while the block is idle; the block does not enforce it.
// The table sits in one synchronous memory of Entries rows read one row a
// cycle unless a stalled result holds the walk. Every operation walks all
// rows through the read pipeline, then register, evict, mark_used, pin and
// unpin write back in the apply state. The last result is then loaded into
// the output register in the emit state (straight after the walk for a
// suggest), and the next operation is taken only once the block is back in
// idle after that result is taken. A suggest gives a result per qualifying
// row, sent when the walk meets the next qualifying row; the last one (or an
// empty result if none qualifies) is the final result.
// The walk holds while a result waits in the output register, so a stalled
// receiver holds the scan without losing anything.
// Reset clears the valid bits of all rows, the total and the threshold; the
// other row fields are written at register and need no clearing.
// ----------------------------------------------------------------------------
module idle_eviction_residency_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  iert_in_if.sink     in_ch,
  iert_out_if.source  out_ch
);
  import iert_pkg::*;

  slot_t                mem [Entries];
  logic [Entries-1:0]   vbit;
  slot_t                rd;
  logic                 rd_live;
  logic [SlotBits-1:0]  rd_idx;
  logic [CntBits-1:0]   addr;
  logic                 addr_live;

  state_t       state, state_next;
  in_t          req;
  logic [31:0]  threshold;
  logic [45:0]  total;
  logic         found;
  logic [SlotBits-1:0] hit;
  logic         have_free;
  logic [SlotBits-1:0] free_idx;
  slot_t        hit_row;
  logic         pend;
  slot_t        pend_row;
  logic [CntBits-1:0] sent;
  logic [2:0]   fin_status;
  out_t         obuf;
  logic         ovalid;

  logic         stall;
  logic         qualifies;
  logic signed [33:0] age;
  logic         key_match;
  logic         walk_done;

  assign stall     = ovalid && !out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid   = ovalid;
  assign out_ch.payload = obuf;

  assign key_match = rd_live && vbit[rd_idx] && rd.key == req.key_tag;
  assign age = 34'(signed'(req.iteration)) - 34'(signed'(rd.last_used))
             - 34'(signed'(threshold));
  assign qualifies = rd_live && vbit[rd_idx] && !rd.pinned && !age[33]
                     && (req.operation == OP_SUGGEST);
  assign walk_done = !addr_live && !rd_live;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_ch.valid) state_next = S_SCAN;
      S_SCAN:  if (!stall && walk_done) begin
                 state_next = (req.operation == OP_SUGGEST) ? S_EMIT : S_APPLY;
               end
      S_APPLY: state_next = S_EMIT;
      S_EMIT:  if (!stall) state_next = S_WAIT;
      S_WAIT:  if (!ovalid || out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // memory walk
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_live <= 1'b0;
      rd_live   <= 1'b0;
      addr      <= '0;
    end else if (state == S_IDLE && in_ch.valid) begin
      addr      <= '0;
      addr_live <= 1'b1;
      rd_live   <= 1'b0;
    end else if (state == S_SCAN && !stall) begin
      rd_live <= addr_live;
      rd_idx  <= addr[SlotBits-1:0];
      if (addr_live) begin
        rd <= mem[addr[SlotBits-1:0]];
        if (addr == CntBits'(Entries - 1)) addr_live <= 1'b0;
        addr <= addr + 1'b1;
      end
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      if (req.operation == OP_REGISTER && fin_status == ST_OK) begin
        mem[free_idx] <= '{valid: 1'b1, key: req.key_tag,
                           alloc: req.allocation_handle,
                           prov: req.provider_handle, size: req.buf_size,
                           last_used: 32'd0, pinned: 1'b0};
      end else if (found) begin
        if (req.operation == OP_MARK_USED) begin
          mem[hit] <= '{valid: 1'b1, key: hit_row.key, alloc: hit_row.alloc,
                        prov: hit_row.prov, size: hit_row.size,
                        last_used: req.iteration, pinned: hit_row.pinned};
        end else if (req.operation == OP_PIN || req.operation == OP_UNPIN) begin
          mem[hit] <= '{valid: 1'b1, key: hit_row.key, alloc: hit_row.alloc,
                        prov: hit_row.prov, size: hit_row.size,
                        last_used: hit_row.last_used,
                        pinned: (req.operation == OP_PIN)};
        end
      end
    end
  end

  // status for non-suggest operations
  always_comb begin
    fin_status = ST_OK;
    case (req.operation)
      OP_REGISTER: begin
        if (req.allocation_handle == 32'd0) fin_status = ST_ZERO;
        else if (found)                     fin_status = ST_DUPLICATE;
        else if (!have_free)                fin_status = ST_FULL;
      end
      OP_MARK_USED, OP_EVICT, OP_PIN, OP_UNPIN: begin
        if (!found) fin_status = ST_NOT_FOUND;
      end
      default: fin_status = ST_OK;
    endcase
  end

  // control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      vbit      <= '0;
      total     <= '0;
      threshold <= '0;
      ovalid    <= 1'b0;
      found     <= 1'b0;
      have_free <= 1'b0;
      pend      <= 1'b0;
      sent      <= '0;
    end else begin
      if (cfg_we) threshold <= cfg_wdata;
      if (ovalid && out_ch.ready) ovalid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          req       <= in_ch.payload;
          found     <= 1'b0;
          have_free <= 1'b0;
          pend      <= 1'b0;
          sent      <= '0;
        end
        S_SCAN: if (!stall && rd_live) begin
          if (key_match && !found) begin
            found   <= 1'b1;
            hit     <= rd_idx;
            hit_row <= rd;
          end
          if (!vbit[rd_idx] && !have_free) begin
            have_free <= 1'b1;
            free_idx  <= rd_idx;
          end
          if (qualifies && sent != CntBits'(Entries)) begin
            pend     <= 1'b1;
            pend_row <= rd;
            if (pend) begin
              ovalid <= 1'b1;
              sent   <= sent + 1'b1;
              obuf   <= '{status: ST_OK, suggestion_valid: 1'b1,
                          suggested_key: pend_row.key,
                          suggested_allocation: pend_row.alloc,
                          suggested_provider: pend_row.prov,
                          suggested_size: pend_row.size,
                          total_bytes: total, last_result: 1'b0};
            end
          end
        end
        S_APPLY: begin
          if (req.operation == OP_REGISTER && fin_status == ST_OK) begin
            vbit[free_idx] <= 1'b1;
            total <= total + 46'(req.buf_size);
          end else if (req.operation == OP_EVICT && found) begin
            vbit[hit] <= 1'b0;
            total <= total - 46'(hit_row.size);
          end
        end
        S_EMIT: if (!stall) begin
          ovalid <= 1'b1;
          if (req.operation == OP_SUGGEST && pend) begin
            obuf <= '{status: ST_OK, suggestion_valid: 1'b1,
                      suggested_key: pend_row.key,
                      suggested_allocation: pend_row.alloc,
                      suggested_provider: pend_row.prov,
                      suggested_size: pend_row.size,
                      total_bytes: total, last_result: 1'b1};
          end else begin
            obuf <= '{status: (req.operation == OP_SUGGEST) ? ST_OK : fin_status,
                      suggestion_valid: 1'b0, suggested_key: 32'd0,
                      suggested_allocation: 32'd0, suggested_provider: 32'd0,
                      suggested_size: 40'd0, total_bytes: total,
                      last_result: 1'b1};
          end
        end
        S_WAIT: ;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/iert_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iert_checker
// Port-level checks on the residency table, bound to the top level.
// ----------------------------------------------------------------------------
module iert_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input iert_pkg::out_t out_payload
);
  import iert_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result dropped under stall");

  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("operation taken while result pending");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_payload.suggestion_valid |->
      out_payload.suggested_key == 32'd0 && out_payload.suggested_size == 40'd0)
    else $error("empty result carries data");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.suggestion_valid |-> out_payload.status == ST_OK)
    else $error("suggestion with bad status");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind idle_eviction_residency_table_top iert_checker u_iert_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);
